// ===== rtl/rbe_pkg.sv =====
`timescale 1ns / 1ps
package rbe_pkg;

    localparam int NUM_AXES        = 3;
    localparam int NUM_LANES       = 2 * NUM_AXES;
    localparam int HEADING_WIDTH   = 16;
    localparam int DM_WIDTH        = 16;
    localparam int REM_WIDTH       = DM_WIDTH + 1;
    localparam int CFG_INDEX_WIDTH = 3;

    // configuration register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MAX_X = 3'd1,
        REG_BOX_MIN_Y = 3'd2,
        REG_BOX_MAX_Y = 3'd3,
        REG_BOX_MIN_Z = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } rbe_reg_index_t;

    // per-ray flags from the front stage; lane 2*i is the min face, 2*i+1 the max face
    typedef struct packed {
        logic                 enclosed;
        logic [NUM_AXES-1:0]  nz;
        logic [NUM_AXES-1:0]  hneg;
        logic [NUM_LANES-1:0] neg;
    } rbe_flags_t;

    // control handed from the slab reduction to the move stages
    typedef struct packed {
        logic                hit;
        logic                go;
        logic [NUM_AXES-1:0] hneg;
    } rbe_move_ctl_t;

endpackage

// ===== rtl/rbe_prep.sv =====
`timescale 1ns / 1ps
module rbe_prep import rbe_pkg::*; #(
    parameter int PW = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [NUM_AXES-1:0][PW-1:0]             in_p,
    input  logic [NUM_AXES-1:0][HEADING_WIDTH-1:0]  in_heading,
    input  logic [NUM_AXES-1:0][PW-1:0]             in_bmin,
    input  logic [NUM_AXES-1:0][PW-1:0]             in_bmax,
    output logic                                    out_valid,
    output logic [NUM_AXES-1:0][PW-1:0]             out_p,
    output logic [NUM_LANES-1:0][PW-1:0]            out_mag,
    output logic [NUM_AXES-1:0][DM_WIDTH-1:0]       out_dm,
    output rbe_flags_t                              out_flags
);

    logic [NUM_LANES-1:0][PW-1:0]      mag_next;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0] dm_next;
    logic [NUM_LANES-1:0]              neg_next;
    logic [NUM_AXES-1:0]               in_box;
    logic [NUM_AXES-1:0]               nz_next;
    logic [NUM_AXES-1:0]               hneg_next;
    rbe_flags_t                        flags_next;

    logic                              valid_reg;
    logic [NUM_AXES-1:0][PW-1:0]       p_reg;
    logic [NUM_LANES-1:0][PW-1:0]      mag_reg;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0] dm_reg;
    rbe_flags_t                        flags_reg;

    // face distances as magnitude plus sign, heading magnitude
    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        logic lo_below;
        logic hi_below;
        assign lo_below     = $signed(in_bmin[i]) < $signed(in_p[i]);
        assign hi_below     = $signed(in_bmax[i]) < $signed(in_p[i]);
        assign hneg_next[i] = in_heading[i][HEADING_WIDTH-1];
        assign nz_next[i]   = in_heading[i] != '0;
        assign dm_next[i]   = hneg_next[i] ? (~in_heading[i] + 1'b1) : in_heading[i];
        assign mag_next[2*i]   = lo_below ? (in_p[i] - in_bmin[i]) : (in_bmin[i] - in_p[i]);
        assign mag_next[2*i+1] = hi_below ? (in_p[i] - in_bmax[i]) : (in_bmax[i] - in_p[i]);
        assign neg_next[2*i]   = lo_below ^ hneg_next[i];
        assign neg_next[2*i+1] = hi_below ^ hneg_next[i];
        assign in_box[i]       = lo_below && ($signed(in_p[i]) < $signed(in_bmax[i]));
    end

    always_comb begin
        flags_next.enclosed = &in_box;
        flags_next.nz       = nz_next;
        flags_next.hneg     = hneg_next;
        flags_next.neg      = neg_next;
    end

    // advance the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= in_p;
            mag_reg   <= mag_next;
            dm_reg    <= dm_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_p     = p_reg;
    assign out_mag   = mag_reg;
    assign out_dm    = dm_reg;
    assign out_flags = flags_reg;

endmodule

// ===== rtl/rbe_div_step.sv =====
`timescale 1ns / 1ps
module rbe_div_step import rbe_pkg::*; #(
    parameter int QW     = 46,
    parameter int SIDE_W = 103
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [NUM_LANES-1:0][REM_WIDTH-1:0]  in_rem,
    input  logic [NUM_LANES-1:0][QW-1:0]         in_sh,
    input  logic [NUM_AXES-1:0][DM_WIDTH-1:0]    in_dm,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [NUM_LANES-1:0][REM_WIDTH-1:0]  out_rem,
    output logic [NUM_LANES-1:0][QW-1:0]         out_sh,
    output logic [NUM_AXES-1:0][DM_WIDTH-1:0]    out_dm,
    output logic [SIDE_W-1:0]                    out_side
);

    logic [NUM_LANES-1:0][REM_WIDTH-1:0] rem_next;
    logic [NUM_LANES-1:0][QW-1:0]        sh_next;

    logic                                valid_reg;
    logic [NUM_LANES-1:0][REM_WIDTH-1:0] rem_reg;
    logic [NUM_LANES-1:0][QW-1:0]        sh_reg;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0]   dm_reg;
    logic [SIDE_W-1:0]                   side_reg;

    // one restoring step per lane: shift in a dividend bit, shift out a quotient bit
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [REM_WIDTH-1:0] trial;
        logic [REM_WIDTH-1:0] divisor;
        logic                 take;
        assign trial       = {in_rem[l][REM_WIDTH-2:0], in_sh[l][QW-1]};
        assign divisor     = {1'b0, in_dm[l/2]};
        assign take        = trial >= divisor;
        assign rem_next[l] = take ? (trial - divisor) : trial;
        assign sh_next[l]  = {in_sh[l][QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            sh_reg   <= sh_next;
            dm_reg   <= in_dm;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_sh    = sh_reg;
    assign out_dm    = dm_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/rbe_reduce.sv =====
`timescale 1ns / 1ps
module rbe_reduce import rbe_pkg::*; #(
    parameter int PW = 32,
    parameter int QW = 46
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [NUM_LANES-1:0][QW-1:0]       in_q,
    input  logic [NUM_AXES-1:0][DM_WIDTH-1:0]  in_dm,
    input  logic [NUM_AXES-1:0][PW-1:0]        in_p,
    input  rbe_flags_t                         in_flags,
    output logic                               out_valid,
    output logic [NUM_AXES-1:0][PW-1:0]        out_p,
    output logic [NUM_AXES-1:0][DM_WIDTH-1:0]  out_dm,
    output logic [PW-1:0]                      out_step,
    output rbe_move_ctl_t                      out_ctl
);

    localparam logic [QW-1:0] HALF    = {{(QW-1){1'b0}}, 1'b1} << (PW-1);
    localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] ONE     = {{(PW-1){1'b0}}, 1'b1};

    function automatic logic [PW-1:0] smax(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic logic [PW-1:0] smin(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    // stage 1: saturate and sign each face distance, order per axis
    logic [NUM_LANES-1:0][PW-1:0]      t_next;
    logic [NUM_AXES-1:0][PW-1:0]       s1_tn_next;
    logic [NUM_AXES-1:0][PW-1:0]       s1_tx_next;

    logic                              s1_valid_reg;
    logic [NUM_AXES-1:0][PW-1:0]       s1_tn_reg;
    logic [NUM_AXES-1:0][PW-1:0]       s1_tx_reg;
    logic [NUM_AXES-1:0][PW-1:0]       s1_p_reg;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0] s1_dm_reg;
    rbe_flags_t                        s1_flags_reg;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [QW-1:0] lim;
        logic [QW-1:0] qs;
        assign lim       = in_flags.neg[l] ? HALF : (HALF - 1'b1);
        assign qs        = (in_q[l] > lim) ? lim : in_q[l];
        assign t_next[l] = in_flags.neg[l] ? (~qs[PW-1:0] + 1'b1) : qs[PW-1:0];
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_order
        assign s1_tn_next[i] = smin(t_next[2*i], t_next[2*i+1]);
        assign s1_tx_next[i] = smax(t_next[2*i], t_next[2*i+1]);
    end

    // stage 2: running entry and exit over the axes with a nonzero heading
    logic [NUM_AXES-1:0][PW-1:0]       ent_cand;
    logic [NUM_AXES-1:0][PW-1:0]       ext_cand;
    logic [PW-1:0]                     s2_amin_next;
    logic [PW-1:0]                     s2_amax_next;

    logic                              s2_valid_reg;
    logic [PW-1:0]                     s2_amin_reg;
    logic [PW-1:0]                     s2_amax_reg;
    logic [NUM_AXES-1:0][PW-1:0]       s2_p_reg;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0] s2_dm_reg;
    rbe_flags_t                        s2_flags_reg;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_cand
        assign ent_cand[i] = s1_flags_reg.nz[i] ? s1_tn_reg[i] : ONE;
        assign ext_cand[i] = s1_flags_reg.nz[i] ? s1_tx_reg[i] : POS_MAX;
    end

    assign s2_amin_next = smax(smax(ent_cand[0], ent_cand[1]), smax(ent_cand[2], ONE));
    assign s2_amax_next = smin(smin(ext_cand[0], ext_cand[1]), ext_cand[2]);

    // stage 3: hit decision and step length
    rbe_move_ctl_t                     s3_ctl_next;
    logic [PW-1:0]                     s3_step_next;

    logic                              s3_valid_reg;
    rbe_move_ctl_t                     s3_ctl_reg;
    logic [PW-1:0]                     s3_step_reg;
    logic [NUM_AXES-1:0][PW-1:0]       s3_p_reg;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0] s3_dm_reg;

    always_comb begin
        s3_ctl_next.go   = !s2_flags_reg.enclosed
                           && ($signed(s2_amin_reg) < $signed(s2_amax_reg))
                           && ($signed(s2_amin_reg) > $signed(PW'(0)));
        s3_ctl_next.hit  = s2_flags_reg.enclosed || s3_ctl_next.go;
        s3_ctl_next.hneg = s2_flags_reg.hneg;
        s3_step_next     = s2_amin_reg + ONE;
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tn_reg    <= s1_tn_next;
            s1_tx_reg    <= s1_tx_next;
            s1_p_reg     <= in_p;
            s1_dm_reg    <= in_dm;
            s1_flags_reg <= in_flags;
            s2_amin_reg  <= s2_amin_next;
            s2_amax_reg  <= s2_amax_next;
            s2_p_reg     <= s1_p_reg;
            s2_dm_reg    <= s1_dm_reg;
            s2_flags_reg <= s1_flags_reg;
            s3_ctl_reg   <= s3_ctl_next;
            s3_step_reg  <= s3_step_next;
            s3_p_reg     <= s2_p_reg;
            s3_dm_reg    <= s2_dm_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_p     = s3_p_reg;
    assign out_dm    = s3_dm_reg;
    assign out_step  = s3_step_reg;
    assign out_ctl   = s3_ctl_reg;

endmodule

// ===== rtl/rbe_move.sv =====
`timescale 1ns / 1ps
module rbe_move import rbe_pkg::*; #(
    parameter int PW = 32,
    parameter int F  = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [NUM_AXES-1:0][PW-1:0]        in_p,
    input  logic [NUM_AXES-1:0][DM_WIDTH-1:0]  in_dm,
    input  logic [PW-1:0]                      in_step,
    input  rbe_move_ctl_t                      in_ctl,
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [NUM_AXES-1:0][PW-1:0]        out_entry
);

    localparam int PRW = PW + DM_WIDTH;
    localparam int XW  = PRW + 1;
    localparam logic signed [XW-1:0] POS_MAX = {{(XW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [XW-1:0] POS_MIN = {{(XW-PW+1){1'b1}}, {(PW-1){1'b0}}};

    // stage 1: step times heading magnitude
    logic [NUM_AXES-1:0][PRW-1:0]  prod_next;

    logic                          m1_valid_reg;
    logic [NUM_AXES-1:0][PRW-1:0]  m1_prod_reg;
    logic [NUM_AXES-1:0][PW-1:0]   m1_p_reg;
    rbe_move_ctl_t                 m1_ctl_reg;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_mul
        assign prod_next[i] = {{DM_WIDTH{1'b0}}, in_step} * {{PW{1'b0}}, in_dm[i]};
    end

    // stage 2: scale, offset, saturate and pick the entry or the start
    logic [NUM_AXES-1:0][PW-1:0]   entry_next;

    logic                          out_valid_reg;
    logic                          hit_reg;
    logic [NUM_AXES-1:0][PW-1:0]   entry_reg;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_add
        logic [PRW-1:0]        scaled;
        logic signed [XW-1:0]  mag_x;
        logic signed [XW-1:0]  p_x;
        logic signed [XW-1:0]  sum;
        logic [PW-1:0]         sat;
        assign scaled = m1_prod_reg[i] >> F;
        assign mag_x  = {1'b0, scaled};
        assign p_x    = {{(XW-PW){m1_p_reg[i][PW-1]}}, m1_p_reg[i]};
        assign sum    = m1_ctl_reg.hneg[i] ? (p_x - mag_x) : (p_x + mag_x);
        assign sat    = (sum > POS_MAX) ? POS_MAX[PW-1:0] :
                        (sum < POS_MIN) ? POS_MIN[PW-1:0] : sum[PW-1:0];
        assign entry_next[i] = m1_ctl_reg.go ? sat : m1_p_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg  <= in_valid;
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_prod_reg <= prod_next;
            m1_p_reg    <= in_p;
            m1_ctl_reg  <= in_ctl;
            hit_reg     <= m1_ctl_reg.hit;
            entry_reg   <= entry_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = hit_reg;
    assign out_entry = entry_reg;

endmodule

// ===== rtl/ray_box_entry_point_core.sv =====
`timescale 1ns / 1ps
// Pipeline: one front stage, one divider stage per quotient bit, three reduction
// stages and two move stages. Throughput: one ray per cycle while the result register
// is not held; the six slab dividers are fully pipelined. Reset (aresetn low,
// synchronous) clears all stage valid bits and sets the six box registers to zero.
module ray_box_entry_point_core import rbe_pkg::*; #(
    parameter int POSITION_WIDTH    = 32,
    parameter int HEADING_FRAC_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [POSITION_WIDTH-1:0]   s_start_x,
    input  logic signed [POSITION_WIDTH-1:0]   s_start_y,
    input  logic signed [POSITION_WIDTH-1:0]   s_start_z,
    input  logic signed [HEADING_WIDTH-1:0]    s_heading_x,
    input  logic signed [HEADING_WIDTH-1:0]    s_heading_y,
    input  logic signed [HEADING_WIDTH-1:0]    s_heading_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [POSITION_WIDTH-1:0]   m_entry_x,
    output logic signed [POSITION_WIDTH-1:0]   m_entry_y,
    output logic signed [POSITION_WIDTH-1:0]   m_entry_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]         cfg_index,
    input  logic [POSITION_WIDTH-1:0]          cfg_data
);

    localparam int PW     = POSITION_WIDTH;
    localparam int DIV_W  = POSITION_WIDTH + HEADING_FRAC_BITS;
    localparam int SIDE_W = NUM_AXES * PW + $bits(rbe_flags_t);

    logic                               en;
    logic [NUM_AXES-1:0][PW-1:0]        bmin_reg;
    logic [NUM_AXES-1:0][PW-1:0]        bmax_reg;

    // whole pipeline advances unless the result register is held
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // box registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bmin_reg <= '0;
            bmax_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rbe_reg_index_t'(cfg_index))
                REG_BOX_MIN_X: bmin_reg[0] <= cfg_data;
                REG_BOX_MAX_X: bmax_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: bmin_reg[1] <= cfg_data;
                REG_BOX_MAX_Y: bmax_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: bmin_reg[2] <= cfg_data;
                REG_BOX_MAX_Z: bmax_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // front stage
    logic                                   prep_valid;
    logic [NUM_AXES-1:0][PW-1:0]            prep_p;
    logic [NUM_LANES-1:0][PW-1:0]           prep_mag;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0]      prep_dm;
    rbe_flags_t                             prep_flags;

    rbe_prep #(.PW(PW)) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_p       ({s_start_z, s_start_y, s_start_x}),
        .in_heading ({s_heading_z, s_heading_y, s_heading_x}),
        .in_bmin    (bmin_reg),
        .in_bmax    (bmax_reg),
        .out_valid  (prep_valid),
        .out_p      (prep_p),
        .out_mag    (prep_mag),
        .out_dm     (prep_dm),
        .out_flags  (prep_flags)
    );

    // divider chain, one quotient bit per stage
    logic                                   div_valid [DIV_W+1];
    logic [NUM_LANES-1:0][REM_WIDTH-1:0]    div_rem   [DIV_W+1];
    logic [NUM_LANES-1:0][DIV_W-1:0]        div_sh    [DIV_W+1];
    logic [NUM_AXES-1:0][DM_WIDTH-1:0]      div_dm    [DIV_W+1];
    logic [SIDE_W-1:0]                      div_side  [DIV_W+1];

    assign div_valid[0] = prep_valid;
    assign div_rem[0]   = '0;
    assign div_dm[0]    = prep_dm;
    assign div_side[0]  = {prep_p, prep_flags};
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_seed
        assign div_sh[0][l] = {prep_mag[l], {HEADING_FRAC_BITS{1'b0}}};
    end

    for (genvar s = 0; s < DIV_W; s++) begin : g_div
        rbe_div_step #(.QW(DIV_W), .SIDE_W(SIDE_W)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[s]),
            .in_rem    (div_rem[s]),
            .in_sh     (div_sh[s]),
            .in_dm     (div_dm[s]),
            .in_side   (div_side[s]),
            .out_valid (div_valid[s+1]),
            .out_rem   (div_rem[s+1]),
            .out_sh    (div_sh[s+1]),
            .out_dm    (div_dm[s+1]),
            .out_side  (div_side[s+1])
        );
    end

    // slab reduction
    logic [NUM_AXES-1:0][PW-1:0]            quo_p;
    rbe_flags_t                             quo_flags;
    logic                                   red_valid;
    logic [NUM_AXES-1:0][PW-1:0]            red_p;
    logic [NUM_AXES-1:0][DM_WIDTH-1:0]      red_dm;
    logic [PW-1:0]                          red_step;
    rbe_move_ctl_t                          red_ctl;

    assign {quo_p, quo_flags} = div_side[DIV_W];

    rbe_reduce #(.PW(PW), .QW(DIV_W)) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid[DIV_W]),
        .in_q      (div_sh[DIV_W]),
        .in_dm     (div_dm[DIV_W]),
        .in_p      (quo_p),
        .in_flags  (quo_flags),
        .out_valid (red_valid),
        .out_p     (red_p),
        .out_dm    (red_dm),
        .out_step  (red_step),
        .out_ctl   (red_ctl)
    );

    // move along the ray and drive the result register
    logic [NUM_AXES-1:0][PW-1:0]            mv_entry;

    rbe_move #(.PW(PW), .F(HEADING_FRAC_BITS)) u_move (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (red_valid),
        .in_p      (red_p),
        .in_dm     (red_dm),
        .in_step   (red_step),
        .in_ctl    (red_ctl),
        .out_valid (m_valid),
        .out_hit   (m_hit),
        .out_entry (mv_entry)
    );

    assign m_entry_x = mv_entry[0];
    assign m_entry_y = mv_entry[1];
    assign m_entry_z = mv_entry[2];

    // no result leaves the block right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an accepted beat always lands in the front stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> prep_valid)
        else $error("accepted beat lost at front stage");

    // an entry from outside always has a step length of at least two and reports a hit
    a_go_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (red_valid && red_ctl.go) |-> (red_ctl.hit && (red_step > {{(PW-1){1'b0}}, 1'b1})))
        else $error("entry step inconsistent with hit decision");

endmodule
